// ----- hw/rtl/fast_unsigned_modulo_top_assert.svh -----
// Assertion macros for the unsigned remainder block checker.
// Used by fum_checker.sv; no other dependencies.
`ifndef FAST_UNSIGNED_MODULO_TOP_ASSERT_SVH
`define FAST_UNSIGNED_MODULO_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define FUM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define FUM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/fum_pkg.sv -----
// Shared types and constants for the unsigned remainder block.
// No dependencies; imported by every RTL module of the block.
`default_nettype none

package fum_pkg;

    localparam int DATA_W   = 32;
    localparam int IN_W     = 2 * DATA_W;
    localparam int CNT_W    = $clog2(DATA_W);

    // Path chosen for one transaction
    typedef enum logic [1:0] {
        PATH_FAST = 2'd0,
        PATH_FOLD = 2'd1,
        PATH_DIV  = 2'd2
    } path_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_FOLD  = 4'b0100,
        ST_WRITE = 4'b1000
    } state_t;

    // Commands from sequencer to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic fold_step;
        logic out_load;
    } cmd_t;

    // Status from datapath to sequencer
    typedef struct packed {
        path_t path;
        logic  fold_done;
    } stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fast_unsigned_modulo_top.sv -----
// Unsigned 32-bit remainder with fast paths for zero dividend, power-of-two
// divisors and divisors of the form 2^s-1.
//
// Usage:
//   Slave channel s_* carries one transaction per operand pair; master
//   channel m_* returns one remainder per transaction, in order.
//   A zero divisor returns the dividend unchanged.
//   Work per path before the result moves to the output register:
//     zero dividend or power-of-two/zero divisor: masked result, no iteration
//     divisor 2^s-1: digit folds until the value is at most the divisor
//     any other divisor: 32 restoring steps on the shared adder
//   The block takes a new transaction only once the last one is handed off;
//   the shared adder and sequencer work on one operand pair at a time and
//   s_tready is low until the result moves to the output register.
//   The output register lets a new transaction enter while the previous
//   result waits; if m_tready stays low, the next result holds in the
//   datapath and s_tready stays low.
//   Reset (rst_n low) returns the sequencer to idle and drops m_tvalid.
// Depends on fum_pkg, fum_dpath and fum_ctrl.
`default_nettype none

module fast_unsigned_modulo_top (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire logic [fum_pkg::IN_W-1:0]    s_tdata,   // [31:0] dividend, [63:32] divisor
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [fum_pkg::DATA_W-1:0]       m_tdata    // [31:0] remainder
);
    import fum_pkg::*;

    cmd_t              cmd;
    stat_t             stat;
    logic [DATA_W-1:0] rem;
    logic              m_tvalid_reg;
    logic [DATA_W-1:0] m_tdata_reg;
    logic              out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    fum_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd)
    );

    fum_dpath u_dpath (
        .clk     (clk),
        .cmd     (cmd),
        .in_data (s_tdata),
        .stat    (stat),
        .rem     (rem)
    );

    // Output register valid: set on hand-off, drop when the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_tdata_reg <= rem;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/fum_dpath.sv -----
// Datapath: operand registers and one shared 34-bit adder used for
// restoring remainder steps and for digit folding. Depends on fum_pkg.
`default_nettype none

module fum_dpath (
    input  wire                              clk,
    input  fum_pkg::cmd_t                    cmd,
    input  wire logic [fum_pkg::IN_W-1:0]    in_data,
    output fum_pkg::stat_t                   stat,
    output logic [fum_pkg::DATA_W-1:0]       rem
);
    import fum_pkg::*;

    logic [DATA_W-1:0] num_in;
    logic [DATA_W-1:0] den_in;
    logic [DATA_W-1:0] den_m1;
    logic [DATA_W-1:0] den_p1;
    logic [DATA_W-1:0] fast_res;
    logic              pow2_or_zero;
    logic              mersenne;
    path_t             path;

    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] num_reg;
    logic [DATA_W-1:0] den_reg;
    logic [CNT_W-1:0]  shamt_reg;

    logic [DATA_W+1:0] add_a;
    logic [DATA_W+1:0] add_b;
    logic              add_cin;
    logic [DATA_W+1:0] add_sum;
    logic              borrow;
    logic              rem_gt;
    logic              rem_eq;

    // Classify the incoming transaction
    always_comb
    begin
        num_in       = in_data[DATA_W-1:0];
        den_in       = in_data[IN_W-1:DATA_W];
        den_m1       = den_in - DATA_W'(1);
        den_p1       = den_in + DATA_W'(1);
        pow2_or_zero = ((den_in & den_m1) == '0);
        mersenne     = (den_p1 != '0) && ((den_in & den_p1) == '0);
        fast_res     = (num_in == '0) ? '0 : (num_in & den_m1);
        if ((num_in == '0) || pow2_or_zero)
        begin
            path = PATH_FAST;
        end
        else if (mersenne)
        begin
            path = PATH_FOLD;
        end
        else
        begin
            path = PATH_DIV;
        end
    end

    // Shared adder: fold adds high digits to low digits, divide subtracts divisor
    always_comb
    begin
        if (cmd.fold_step)
        begin
            add_a   = {2'b00, rem_reg >> shamt_reg};
            add_b   = {2'b00, rem_reg & den_reg};
            add_cin = 1'b0;
        end
        else
        begin
            add_a   = {1'b0, rem_reg, num_reg[DATA_W-1]};
            add_b   = ~{2'b00, den_reg};
            add_cin = 1'b1;
        end
        add_sum = add_a + add_b + {{(DATA_W+1){1'b0}}, add_cin};
        borrow  = add_sum[DATA_W+1];
    end

    assign rem_gt = (rem_reg > den_reg);
    assign rem_eq = (rem_reg == den_reg);

    // Operand and partial remainder registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            num_reg   <= num_in;
            den_reg   <= den_in;
            shamt_reg <= CNT_W'($countones(den_in));
            case (path)
                PATH_FAST: rem_reg <= fast_res;
                PATH_FOLD: rem_reg <= num_in;
                default:   rem_reg <= '0;
            endcase
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[DATA_W-2:0], 1'b0};
            if (borrow)
            begin
                rem_reg <= add_a[DATA_W-1:0];
            end
            else
            begin
                rem_reg <= add_sum[DATA_W-1:0];
            end
        end
        else if (cmd.fold_step)
        begin
            if (rem_gt)
            begin
                rem_reg <= add_sum[DATA_W-1:0];
            end
            else if (rem_eq)
            begin
                rem_reg <= '0;
            end
        end
    end

    assign stat.path      = path;
    assign stat.fold_done = !rem_gt;
    assign rem            = rem_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/fum_ctrl.sv -----
// Sequencer: steps the shared datapath through load, divide or fold
// iterations, and the hand-off to the output register. Depends on fum_pkg.
`default_nettype none

module fum_ctrl (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            in_valid,
    output logic           in_ready,
    input  wire            out_free,
    input  fum_pkg::stat_t stat,
    output fum_pkg::cmd_t  cmd
);
    import fum_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    case (stat.path)
                        PATH_FAST: state_next = ST_WRITE;
                        PATH_FOLD: state_next = ST_FOLD;
                        default:   state_next = ST_DIV;
                    endcase
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == '1)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_FOLD:
            begin
                cmd.fold_step = 1'b1;
                if (stat.fold_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and iteration counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/fum_checker.sv -----
// Port-level checker for the unsigned remainder block, bound to the top.
// Depends on fum_pkg and fast_unsigned_modulo_top_assert.svh.
`default_nettype none

`include "fast_unsigned_modulo_top_assert.svh"

module fum_checker (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              s_tvalid,
    input wire                              s_tready,
    input wire                              m_tvalid,
    input wire                              m_tready,
    input wire [fum_pkg::DATA_W-1:0]        m_tdata
);
    import fum_pkg::*;

    // Hold a stalled result
    `FUM_ASSERT_NEXT(a_out_valid_hold, m_tvalid && !m_tready, m_tvalid, "m_tvalid dropped")
    `FUM_ASSERT_NEXT(a_out_data_hold, m_tvalid && !m_tready, $stable(m_tdata), "m_tdata changed")
    // Busy after every accepted transaction
    `FUM_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "back to back accept")
    // A new result appears only as the sequencer returns to idle
    `FUM_ASSERT_SAME(a_idle_on_result, $rose(m_tvalid), s_tready, "result without idle")

endmodule

bind fast_unsigned_modulo_top fum_checker u_fum_checker (.*);

`default_nettype wire

// ----- test/fast_unsigned_modulo_top_tb.sv -----
// Self-checking testbench for fast_unsigned_modulo_top: streams operand pairs in and
// compares every remainder against an in-order prediction.
// Depends on fum_pkg and the fast_unsigned_modulo_top RTL only.
`timescale 1ns / 100ps

module fast_unsigned_modulo_top_tb;

    import fum_pkg::*;

    typedef logic [DATA_W-1:0] word_t;

    localparam int          CLK_PERIOD   = 12;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          IDLE_PCT     = 34;
    localparam int          MAX_REPORTS  = 50;
    localparam word_t       ALL_ONES     = '1;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata  = '0;    // [31:0] dividend, [63:32] divisor
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;          // [31:0] remainder

    word_t       expected_remainders[$];
    word_t       want_remainder;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit          no_idle     = 1'b0;

    fast_unsigned_modulo_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running clock
    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Predict the remainder: zero dividend, mask for 2^k or zero, digit fold
    // for 2^s-1 (all-ones excluded), plain remainder otherwise
    function automatic word_t calc_remainder(input word_t dividend, input word_t divisor);
        word_t       div_plus1;
        word_t       acc;
        int unsigned digit_w;
        if (dividend == '0)
            return '0;
        if ((divisor & (divisor - 32'd1)) == '0)
            return dividend & (divisor - 32'd1);
        div_plus1 = divisor + 32'd1;
        if (div_plus1 != '0 && (div_plus1 & divisor) == '0)
        begin
            digit_w = $countones(divisor);
            acc     = dividend;
            while (acc > divisor)
                acc = (acc >> digit_w) + (acc & divisor);
            return (acc == divisor) ? '0 : acc;
        end
        return dividend % divisor;
    endfunction

    function automatic word_t pick_pow2_divisor();
        if ($urandom_range(9) == 0)
            return '0;
        return 32'd1 << $urandom_range(31);
    endfunction

    function automatic word_t pick_fold_divisor();
        return (32'd1 << $urandom_range(31, 2)) - 32'd1;
    endfunction

    function automatic word_t pick_general_divisor();
        case ($urandom_range(9))
            0:       return ALL_ONES;
            1, 2:    return $urandom_range(1000, 3);
            3:       return $urandom_range(32'hFFFF, 3);
            default: return $urandom;
        endcase
    endfunction

    function automatic word_t pick_any_divisor();
        case ($urandom_range(5))
            0:       return pick_pow2_divisor();
            1, 2:    return pick_fold_divisor();
            default: return pick_general_divisor();
        endcase
    endfunction

    // Bias dividends toward zero, the divisor itself, multiples and full range
    function automatic word_t pick_dividend(input word_t divisor);
        case ($urandom_range(11))
            0:       return '0;
            1:       return divisor;
            2:       return ALL_ONES;
            3:       return divisor * $urandom_range(64, 2);
            4:       return divisor * $urandom_range(64, 2) + $urandom_range(3);
            5:       return $urandom_range(255);
            default: return $urandom;
        endcase
    endfunction

    // Offer one operand pair and hold it until the block takes it
    task automatic send_operands(input word_t dividend, input word_t divisor);
        int unsigned gap;
        gap = 0;
        if (!no_idle && $urandom_range(99) < IDLE_PCT)
            gap = $urandom_range(6, 1);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {divisor, dividend};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic test_directed();
        send_operands(32'd0,          32'd0);
        send_operands(32'd0,          32'd7);
        send_operands(32'd0,          ALL_ONES);
        send_operands(ALL_ONES,       32'd0);
        send_operands(32'h1234_5678,  32'd0);
        send_operands(ALL_ONES,       32'd1);
        send_operands(32'd5,          32'd1);
        send_operands(ALL_ONES,       32'h8000_0000);
        send_operands(32'h8765_4321,  32'd16);
        send_operands(32'd7,          32'd7);
        send_operands(32'd14,         32'd7);
        send_operands(ALL_ONES,       32'd3);
        send_operands(32'd2,          32'd3);
        send_operands(ALL_ONES,       32'h7FFF_FFFF);
        send_operands(32'h7FFF_FFFF,  32'h7FFF_FFFF);
        send_operands(32'h5555_5555,  32'hFFFF);
        send_operands(ALL_ONES,       ALL_ONES);
        send_operands(32'hFFFF_FFFE,  ALL_ONES);
        send_operands(32'd12345,      ALL_ONES);
        send_operands(ALL_ONES,       32'd10);
        send_operands(32'd100,        32'd101);
        send_operands(32'h8000_0000,  32'hFFFF_FFFD);
        send_operands(32'd1,          32'h8000_0001);
    endtask

    task automatic test_mask_path(input int unsigned count);
        word_t divisor;
        repeat (count)
        begin
            divisor = pick_pow2_divisor();
            send_operands(pick_dividend(divisor), divisor);
        end
    endtask

    task automatic test_fold_path(input int unsigned count);
        word_t divisor;
        repeat (count)
        begin
            divisor = pick_fold_divisor();
            send_operands(pick_dividend(divisor), divisor);
        end
    endtask

    task automatic test_general_path(input int unsigned count);
        word_t divisor;
        repeat (count)
        begin
            divisor = pick_general_divisor();
            send_operands(pick_dividend(divisor), divisor);
        end
    endtask

    // Mixed paths with both sides kept busy, then with idling again
    task automatic test_back_to_back(input int unsigned count);
        word_t divisor;
        no_idle = 1'b1;
        repeat (count)
        begin
            divisor = pick_any_divisor();
            send_operands(pick_dividend(divisor), divisor);
        end
        no_idle = 1'b0;
        repeat (count)
        begin
            divisor = pick_any_divisor();
            send_operands(pick_dividend(divisor), divisor);
        end
    endtask

    // Stall the result channel at random unless idling is off
    always @(posedge clk)
    begin
        m_tready <= rst_n && (no_idle || ($urandom_range(99) >= IDLE_PCT));
    end

    // Record each accepted operand pair and check each accepted remainder
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_remainders.push_back(
                    calc_remainder(s_tdata[DATA_W-1:0], s_tdata[IN_W-1:DATA_W]));
            if (m_tvalid && m_tready)
            begin
                if (expected_remainders.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: unexpected remainder transaction: expected none, got %h",
                                 $time, m_tdata);
                end
                else
                begin
                    want_remainder = expected_remainders.pop_front();
                    if (m_tdata !== want_remainder)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("%0t: remainder mismatch: expected %h, got %h",
                                     $time, want_remainder, m_tdata);
                    end
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_mask_path(250);
        test_fold_path(350);
        test_general_path(450);
        test_back_to_back(200);
        s_tvalid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (expected_remainders.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_remainders.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/fum_pkg.sv
hw/rtl/fum_dpath.sv
hw/rtl/fum_ctrl.sv
hw/rtl/fast_unsigned_modulo_top.sv
hw/rtl/fum_checker.sv
test/fast_unsigned_modulo_top_tb.sv
